FILE: design/lgs_pkg.sv
// ============================================================================
// lgs_pkg
// Shared constants and types for the life generation stream block.
// ============================================================================
package lgs_pkg;

  localparam int MAX_COLS = 512;
  localparam int MAX_ROWS = 512;

  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COLS_W   = COL_W + 1;
  localparam int ROWS_W   = ROW_W + 1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;
  localparam int POS_W     = 9;
  localparam int MIN_SIZE  = 3;
  localparam int BORDER    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(1);

  // one cell on its way from the counters to the evaluation stage
  typedef struct packed {
    logic             alive;
    logic [COL_W-1:0] addr;
    logic             emit;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } item_t;

  // line buffer write port: {upper, middle}
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [1:0]       data;
  } line_wr_t;

endpackage

FILE: design/lgs_if.sv
// ============================================================================
// lgs_if
// Channel interfaces: cell input, result output and register write.
// ============================================================================
interface lgs_cell_if;
  logic valid;
  logic ready;
  logic cell_alive;
  logic frame_start;

  modport source (output valid, output cell_alive, output frame_start, input ready);
  modport sink   (input valid, input cell_alive, input frame_start, output ready);
endinterface

interface lgs_res_if;
  logic                    valid;
  logic                    ready;
  logic                    next_alive;
  logic [lgs_pkg::POS_W-1:0] out_row;
  logic [lgs_pkg::POS_W-1:0] out_col;
  logic                    frame_end;

  modport source (output valid, output next_alive, output out_row, output out_col,
                  output frame_end, input ready);
  modport sink   (input valid, input next_alive, input out_row, input out_col,
                  input frame_end, output ready);
endinterface

interface lgs_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [lgs_pkg::CFG_IDX_W-1:0] index;
  logic [lgs_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/lgs_line_mem.sv
// ============================================================================
// lgs_line_mem
// Both line buffers in one synchronous memory, {upper, middle} per column.
// ============================================================================
module lgs_line_mem (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [lgs_pkg::COL_W-1:0] rd_addr_i,
  input  lgs_pkg::line_wr_t         wr_i,
  output logic [1:0]                rd_data_o
);

  logic [1:0] mem_q [lgs_pkg::MAX_COLS];
  logic [1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/lgs_cell_eval.sv
// ============================================================================
// lgs_cell_eval
// Read-modify-write stage: line buffer merge with forwarding, 3x3 window,
// B3/S23 rule and the output register.
// ============================================================================
module lgs_cell_eval (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      acc_i,
  input  lgs_pkg::item_t            item_i,
  input  logic [1:0]                rd_data_i,
  output logic                      ready_o,
  output lgs_pkg::line_wr_t         wr_o,
  lgs_res_if.source                 res_o
);

  logic           s1_valid_q;
  lgs_pkg::item_t s1_q;
  logic           fwd_q;
  logic [1:0]     fwd_data_q;
  logic [8:0]     window_q;
  logic [8:0]     window_d;
  logic           out_valid_q;
  logic           next_q;
  logic [lgs_pkg::POS_W-1:0] row_q;
  logic [lgs_pkg::POS_W-1:0] col_q;
  logic           last_q;

  logic       top_b;
  logic       mid_b;
  logic       commit;
  logic [3:0] pop;
  logic [3:0] nbrs;
  logic       next_b;

  assign top_b  = fwd_q ? fwd_data_q[1] : rd_data_i[1];
  assign mid_b  = fwd_q ? fwd_data_q[0] : rd_data_i[0];
  assign commit = s1_valid_q && (!s1_q.emit || !out_valid_q || res_o.ready);
  assign ready_o = !s1_valid_q || commit;

  assign wr_o.en   = commit;
  assign wr_o.addr = s1_q.addr;
  assign wr_o.data = {mid_b, s1_q.alive};

  assign window_d = {window_q[7:6], s1_q.alive, window_q[4:3], mid_b, window_q[1:0], top_b};

  always_comb begin
    pop = '0;
    for (int i = 0; i < 9; i++) begin
      pop = pop + 4'(window_d[i]);
    end
    nbrs   = pop - 4'(window_d[4]);
    next_b = (nbrs == 4'd3) || (window_d[4] && nbrs == 4'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      window_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc_i) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= commit && (s1_q.addr == item_i.addr);
      end else if (commit) begin
        s1_valid_q <= 1'b0;
      end
      if (commit) begin
        window_q <= window_d;
      end
      if (commit && s1_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_q       <= item_i;
      fwd_data_q <= wr_o.data;
    end
    if (commit && s1_q.emit) begin
      next_q <= next_b;
      row_q  <= s1_q.row;
      col_q  <= s1_q.col;
      last_q <= s1_q.last;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.next_alive = next_q;
  assign res_o.out_row    = row_q;
  assign res_o.out_col    = col_q;
  assign res_o.frame_end  = last_q;

  a_acc_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i |=> s1_valid_q)
    else $error("accepted transaction did not reach the evaluation stage");

  a_fwd_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q && !s1_valid_q |-> !$past(acc_i))
    else $error("forward flag set without a pending transaction");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_o.ready |=> out_valid_q && $stable(row_q) && $stable(col_q))
    else $error("pending result overwritten");

endmodule

FILE: design/life_generation_stream.sv
// ============================================================================
// life_generation_stream
// One B3/S23 life generation over a raster cell stream.
//
//   channel  dir  transaction
//   cell_i   in   cell_alive, frame_start
//   res_o    out  next_alive, out_row, out_col, frame_end (interior cells)
//   cfg_i    in   index (0 grid_rows, 1 grid_cols), data
//
// One cell per cycle while results are taken; results are registered.
// The line buffer memory does one read and one write per cell; a write and
// a read of the same column in one cycle are resolved by forwarding.
// Reset clears counters and the window; line buffer contents are refilled
// by each frame before use. A stalled result holds the evaluation stage,
// which then stops taking cells; cfg_i is always ready.
// ============================================================================
module life_generation_stream (
  input  logic       clk_i,
  input  logic       rst_ni,
  lgs_cell_if.sink   cell_i,
  lgs_res_if.source  res_o,
  lgs_cfg_if.sink    cfg_i
);

  logic [lgs_pkg::ROWS_W-1:0] rows_q;
  logic [lgs_pkg::COLS_W-1:0] cols_q;
  logic [lgs_pkg::ROW_W-1:0]  row_q, row_d;
  logic [lgs_pkg::COL_W-1:0]  col_q, col_d;

  logic [lgs_pkg::ROW_W-1:0]  r;
  logic [lgs_pkg::COL_W-1:0]  c;
  logic [lgs_pkg::ROW_W-1:0]  r_m1;
  logic [lgs_pkg::COL_W-1:0]  c_m1;
  logic                       acc;
  logic                       ready;
  logic                       cfg_wr;
  lgs_pkg::item_t             item;
  lgs_pkg::line_wr_t          wr;
  logic [1:0]                 rd_data;
  logic [lgs_pkg::CFG_DAT_W-1:0] val;

  assign acc    = cell_i.valid && ready;
  assign cell_i.ready = ready;
  assign cfg_i.ready  = 1'b1;
  assign cfg_wr = cfg_i.valid &&
                  (cfg_i.index == lgs_pkg::REG_GRID_ROWS ||
                   cfg_i.index == lgs_pkg::REG_GRID_COLS);
  assign val    = cfg_i.data;

  always_comb begin
    r = (cell_i.frame_start || {1'b0, row_q} >= rows_q) ? '0 : row_q;
    c = (cell_i.frame_start || {1'b0, col_q} >= cols_q) ? '0 : col_q;
    r_m1 = r - lgs_pkg::ROW_W'(1);
    c_m1 = c - lgs_pkg::COL_W'(1);

    item.alive = cell_i.cell_alive;
    item.addr  = c;
    item.emit  = (r >= lgs_pkg::ROW_W'(lgs_pkg::BORDER)) &&
                 (c >= lgs_pkg::COL_W'(lgs_pkg::BORDER));
    item.row   = lgs_pkg::POS_W'(r_m1);
    item.col   = lgs_pkg::POS_W'(c_m1);
    item.last  = ({1'b0, r} == rows_q - lgs_pkg::ROWS_W'(1)) &&
                 ({1'b0, c} == cols_q - lgs_pkg::COLS_W'(1));

    row_d = r;
    col_d = c + lgs_pkg::COL_W'(1);
    if ({1'b0, c} + lgs_pkg::COLS_W'(1) >= cols_q) begin
      col_d = '0;
      row_d = ({1'b0, r} + lgs_pkg::ROWS_W'(1) >= rows_q) ? '0 : r + lgs_pkg::ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= lgs_pkg::ROWS_W'(300 > lgs_pkg::MAX_ROWS ? lgs_pkg::MAX_ROWS : 300);
      cols_q <= lgs_pkg::COLS_W'(300 > lgs_pkg::MAX_COLS ? lgs_pkg::MAX_COLS : 300);
      row_q  <= '0;
      col_q  <= '0;
    end else if (cfg_wr) begin
      if (cfg_i.index == lgs_pkg::REG_GRID_ROWS) begin
        if (val < lgs_pkg::CFG_DAT_W'(lgs_pkg::MIN_SIZE)) begin
          rows_q <= lgs_pkg::ROWS_W'(lgs_pkg::MIN_SIZE);
        end else if (32'(val) > lgs_pkg::MAX_ROWS) begin
          rows_q <= lgs_pkg::ROWS_W'(lgs_pkg::MAX_ROWS);
        end else begin
          rows_q <= lgs_pkg::ROWS_W'(val);
        end
      end else begin
        if (val < lgs_pkg::CFG_DAT_W'(lgs_pkg::MIN_SIZE)) begin
          cols_q <= lgs_pkg::COLS_W'(lgs_pkg::MIN_SIZE);
        end else if (32'(val) > lgs_pkg::MAX_COLS) begin
          cols_q <= lgs_pkg::COLS_W'(lgs_pkg::MAX_COLS);
        end else begin
          cols_q <= lgs_pkg::COLS_W'(val);
        end
      end
      row_q <= '0;
      col_q <= '0;
    end else if (acc) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  lgs_line_mem u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (acc),
    .rd_addr_i (c),
    .wr_i      (wr),
    .rd_data_o (rd_data)
  );

  lgs_cell_eval u_cell_eval (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .item_i    (item),
    .rd_data_i (rd_data),
    .ready_o   (ready),
    .wr_o      (wr),
    .res_o     (res_o)
  );

  a_start_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && cell_i.frame_start && !cfg_i.valid |=> col_q == lgs_pkg::COL_W'(1) && row_q == '0)
    else $error("frame start did not restart the raster position");

  a_pos_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cfg_i.valid) |-> {1'b0, row_q} < rows_q && {1'b0, col_q} < cols_q)
    else $error("raster position outside the grid");

  a_sizes_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_q >= lgs_pkg::ROWS_W'(lgs_pkg::MIN_SIZE) && cols_q >= lgs_pkg::COLS_W'(lgs_pkg::MIN_SIZE))
    else $error("grid size below minimum");

endmodule

FILE: tb/sv/life_generation_stream_checker.sv
// ============================================================================
// life_generation_stream_checker
// Watches the cell, result and register channels of the life generation
// block. Keeps its own copy of the line buffers, the 3x3 window, the raster
// position and the grid size. Every accepted cell transaction that completes
// an interior position produces its expected next-generation cell.
// Accepted results are compared field by field in order.
// ============================================================================
module life_generation_stream_checker
  import lgs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic end_check_i,
  lgs_cell_if  cell_mon,
  lgs_res_if   res_mon,
  lgs_cfg_if   cfg_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   results_o
);

  typedef struct packed {
    logic             alive;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } life_cell_t;

  life_cell_t next_gen_q[$];

  logic       upper_row  [MAX_COLS];
  logic       middle_row [MAX_COLS];
  logic [8:0] win;
  int         row_pos;
  int         col_pos;
  int         rows_eff;
  int         cols_eff;
  bit         leftovers_done;

  function automatic int clamp_dim(input logic [CFG_DAT_W-1:0] v, input int top);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > top) return top;
    return int'(v);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    fail_count_o++;
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
    case (idx)
      REG_GRID_ROWS: begin
        rows_eff = clamp_dim(val, MAX_ROWS);
        row_pos  = 0;
        col_pos  = 0;
      end
      REG_GRID_COLS: begin
        cols_eff = clamp_dim(val, MAX_COLS);
        row_pos  = 0;
        col_pos  = 0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic evolve_cell(input logic alive, input logic fs);
    logic       top_c;
    logic       mid_c;
    logic [2:0] wt;
    logic [2:0] wm;
    logic [2:0] wb;
    int         nbrs;
    life_cell_t nxt;
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (col_pos >= cols_eff) col_pos = 0;
    if (row_pos >= rows_eff) row_pos = 0;
    top_c = upper_row[col_pos];
    mid_c = middle_row[col_pos];
    upper_row[col_pos]  = mid_c;
    middle_row[col_pos] = alive;
    wt  = {win[1:0], top_c};
    wm  = {win[4:3], mid_c};
    wb  = {win[7:6], alive};
    win = {wb, wm, wt};
    if (row_pos >= BORDER && col_pos >= BORDER) begin
      nbrs      = $countones(win) - int'(wm[1]);
      nxt.alive = wm[1] ? (nbrs == 2 || nbrs == 3) : (nbrs == 3);
      nxt.row   = POS_W'(row_pos - 1);
      nxt.col   = POS_W'(col_pos - 1);
      nxt.last  = (row_pos == rows_eff - 1) && (col_pos == cols_eff - 1);
      next_gen_q.push_back(nxt);
    end
    if (col_pos + 1 >= cols_eff) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= rows_eff) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  task automatic check_result();
    life_cell_t exp_c;
    results_o++;
    if (next_gen_q.size() == 0) begin
      report_mismatch($sformatf("result at r%0d c%0d with no cell pending",
                                res_mon.out_row, res_mon.out_col));
    end else begin
      exp_c = next_gen_q.pop_front();
      if (res_mon.next_alive !== exp_c.alive)
        report_mismatch($sformatf("next_alive at r%0d c%0d: exp %0b got %0b",
                                  exp_c.row, exp_c.col, exp_c.alive, res_mon.next_alive));
      if (res_mon.out_row !== exp_c.row)
        report_mismatch($sformatf("out_row: exp %0d got %0d", exp_c.row, res_mon.out_row));
      if (res_mon.out_col !== exp_c.col)
        report_mismatch($sformatf("out_col: exp %0d got %0d", exp_c.col, res_mon.out_col));
      if (res_mon.frame_end !== exp_c.last)
        report_mismatch($sformatf("frame_end at r%0d c%0d: exp %0b got %0b",
                                  exp_c.row, exp_c.col, exp_c.last, res_mon.frame_end));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (upper_row[i]) begin
        upper_row[i]  = 1'b0;
        middle_row[i] = 1'b0;
      end
      win            = '0;
      row_pos        = 0;
      col_pos        = 0;
      rows_eff       = 300;
      cols_eff       = 300;
      leftovers_done = 1'b0;
      fail_count_o   = 0;
      results_o      = 0;
      next_gen_q.delete();
      pending_o      = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) apply_write(cfg_mon.index, cfg_mon.data);
      if (cell_mon.valid && cell_mon.ready) evolve_cell(cell_mon.cell_alive, cell_mon.frame_start);
      if (res_mon.valid && res_mon.ready) check_result();
      if (end_check_i && !leftovers_done) begin
        leftovers_done = 1'b1;
        if (next_gen_q.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", next_gen_q.size()));
      end
      pending_o = next_gen_q.size();
    end
  end

endmodule

FILE: tb/sv/life_generation_stream_tb.sv
// ============================================================================
// life_generation_stream_tb
// Drives raster cell frames and grid size writes into the life generation
// block with random idling on the cell and result channels, and reports
// the verdict from the checker's mismatch count. Directed frames cover birth,
// survival, overcrowding, an abandoned frame and an unused register index;
// random frames cover small grids and clamped sizes; short runs cover sides
// clamped to the largest grid.
// ============================================================================
module life_generation_stream_tb;
  import lgs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_CELLS    = 140;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

  localparam logic [8:0] SURVIVE_TWO = 9'b000_110_001;
  localparam logic [8:0] BIRTH_THREE = 9'b001_000_101;
  localparam logic [8:0] CROWDED     = 9'b111_111_111;

  logic clk;
  logic rst_n;
  logic end_check;
  int   send_idle;
  int   recv_idle;
  int   fail_count;
  int   pending;
  int   results;
  int   cells_sent;
  int   writes_done;
  int   stall_cycles;
  int   grid_rows;
  int   grid_cols;

  lgs_cell_if cell_if ();
  lgs_res_if  res_if ();
  lgs_cfg_if  cfg_if ();

  life_generation_stream i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cell_i (cell_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  life_generation_stream_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .end_check_i  (end_check),
    .cell_mon     (cell_if),
    .res_mon      (res_if),
    .cfg_mon      (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    res_if.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((cell_if.valid && cell_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic int applied_size(input logic [CFG_DAT_W-1:0] v, input int top);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > top) return top;
    return int'(v);
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_dim();
    if ($urandom_range(0, 99) < 8) return CFG_DAT_W'($urandom_range(0, 2));
    return CFG_DAT_W'($urandom_range(3, 10));
  endfunction

  task automatic send_cell(input logic alive, input logic fs);
    while ($urandom_range(0, 99) < send_idle) begin
      cell_if.valid <= 1'b0;
      @(negedge clk);
    end
    cell_if.valid       <= 1'b1;
    cell_if.cell_alive  <= alive;
    cell_if.frame_start <= fs;
    do @(posedge clk); while (!cell_if.ready);
    @(negedge clk);
    cells_sent++;
  endtask

  task automatic pause_stream();
    cell_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] val, input bit last_one);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    writes_done++;
    if (last_one) cfg_if.valid <= 1'b0;
  endtask

  task automatic resize(input logic [CFG_DAT_W-1:0] rows_val,
                        input logic [CFG_DAT_W-1:0] cols_val);
    pause_stream();
    write_reg(REG_GRID_ROWS, rows_val, 1'b0);
    write_reg(REG_GRID_COLS, cols_val, 1'b1);
    grid_rows = applied_size(rows_val, MAX_ROWS);
    grid_cols = applied_size(cols_val, MAX_COLS);
  endtask

  task automatic send_pattern(input logic [8:0] pat, input int first_idx,
                              input int last_idx, input logic mark);
    for (int i = first_idx; i <= last_idx; i++) send_cell(pat[i], mark && i == 0);
  endtask

  // early frame_start now and then abandons the running frame
  task automatic send_cells(input int count, input int density, input logic mark);
    logic fs;
    for (int i = 0; i < count; i++) begin
      fs = (i == 0) ? mark : ($urandom_range(0, 299) == 0);
      send_cell($urandom_range(0, 99) < density, fs);
    end
  endtask

  task automatic send_frame(input int density, input logic mark);
    send_cells(grid_rows * grid_cols, density, mark);
  endtask

  initial begin
    int  phase_end;
    bit  fresh;
    rst_n               = 1'b0;
    end_check           = 1'b0;
    cell_if.valid       = 1'b0;
    cell_if.cell_alive  = 1'b0;
    cell_if.frame_start = 1'b0;
    res_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_GRID_ROWS;
    cfg_if.data         = '0;
    send_idle           = 32;
    recv_idle           = 49;
    cells_sent          = 0;
    writes_done         = 0;
    stall_cycles        = 0;
    grid_rows           = 300;
    grid_cols           = 300;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // 3x3 grid: one interior cell per frame
    resize(CFG_DAT_W'(0), CFG_DAT_W'(1));
    send_pattern(SURVIVE_TWO, 0, 8, 1'b1);
    send_pattern(BIRTH_THREE, 0, 3, 1'b0);
    pause_stream();
    write_reg(REG_SPARE, '1, 1'b1);
    send_pattern(BIRTH_THREE, 4, 8, 1'b0);
    send_cell(1'b1, 1'b0);
    send_pattern(CROWDED, 0, 8, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 32 : (phase == 1) ? 49 : 0;
      recv_idle = (phase == 0) ? 49 : (phase == 1) ? 32 : 0;
      phase_end = cells_sent + PHASE_CELLS;
      fresh     = 1'b1;
      while (cells_sent < phase_end) begin
        if (fresh || $urandom_range(0, 99) < 35) resize(pick_dim(), pick_dim());
        else if ($urandom_range(0, 9) == 0) pause_stream();
        fresh = 1'b0;
        send_frame($urandom_range(10, 70), $urandom_range(0, 99) < 85);
      end
    end

    // sides clamped to the maximum, the other side kept minimal; first rows only
    resize('1, CFG_DAT_W'(2));
    send_cells(90, 40, 1'b1);
    resize(CFG_DAT_W'(3), '1);
    send_cells(60, 40, 1'b1);

    pause_stream();
    end_check = 1'b1;
    @(posedge clk);
    @(negedge clk);
    $display("covered %0d cell transactions and %0d register writes, 3x3 to clamped grids",
             cells_sent, writes_done);
    $display("checked %0d results under three sender/receiver idle mixes", results);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
design/lgs_pkg.sv
design/lgs_if.sv
design/lgs_line_mem.sv
design/lgs_cell_eval.sv
design/life_generation_stream.sv
tb/sv/life_generation_stream_checker.sv
tb/sv/life_generation_stream_tb.sv
